[sv/ssm_pkg.sv]
// Shared types and codes for the seven-segment display multiplexer.
// No dependencies; every other file of the block imports this package.
package ssm_pkg;

  localparam int unsigned DIGIT_COUNT = 4;
  localparam int unsigned SEG_W       = 8;

  // request operation codes
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_NUMBER = 3'd1,
    OP_TIME   = 3'd2,
    OP_COLON  = 3'd3,
    OP_BLANK  = 3'd4
  } opcode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SEG_POL = 2'd0,
    CFG_DIG_POL = 2'd1
  } cfg_index_e;

  // one font byte per digit, leftmost digit at index 0
  typedef logic [DIGIT_COUNT-1:0][SEG_W-1:0] frame_t;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] number_value;
    logic [7:0]  minutes;
    logic [7:0]  seconds;
    logic        colon_on;
  } req_t;

  typedef struct packed {
    logic [SEG_W-1:0]       segment_lines;
    logic [DIGIT_COUNT-1:0] digit_lines;
  } res_t;

endpackage

[sv/seven_segment_mux_driver.sv]
// Top level of the four-digit seven-segment display multiplexer.
// Depends on ssm_pkg and ssm_frame_gen.
//
// Each request (tick, show number, show time, set colon, blank) returns exactly one
// result with the segment and digit pin levels as they stand after that request.
// Requests pass an input register, then decode and frame update into the result
// register: one request per clock is sustained while results are taken, and the
// result is offered from the result register once the request leaves the input
// register. The input register holds a request while the result register
// waits. Write requests change only the frame store and colon; the new frame shows on
// the next tick. Polarity registers are written through the configuration port, which
// is always ready, and apply to the next result.
module seven_segment_mux_driver (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ssm_pkg::req_t        in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ssm_pkg::res_t        out_res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  ssm_pkg::cfg_index_e  cfg_index_i,
  input  logic                 cfg_data_i
);
  import ssm_pkg::*;

  localparam logic [SEG_W-1:0] DP_MASK = 8'h80;
  localparam logic [1:0]       COLON_DIGIT = 2'd1;

  logic                   in_valid_q;
  req_t                   in_req_q;
  logic                   out_valid_q;
  res_t                   out_res_q, out_res_d;
  logic                   advance;
  logic                   seg_pol_q, dig_pol_q;
  frame_t                 frame_q, frame_d;
  logic                   colon_q, colon_d;
  logic [1:0]             scan_q, scan_d;
  logic [SEG_W-1:0]       seg_drive_q, seg_drive_d;
  logic [DIGIT_COUNT-1:0] dig_drive_q, dig_drive_d;
  frame_t                 num_frame, time_frame;

  // handshakes
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign cfg_ready_o = 1'b1;

  // polarity registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_pol_q <= 1'b0;
      dig_pol_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SEG_POL: seg_pol_q <= cfg_data_i;
        CFG_DIG_POL: dig_pol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
  end

  ssm_frame_gen u_frame_gen (
    .num_value_i  (in_req_q.number_value),
    .minutes_i    (in_req_q.minutes),
    .seconds_i    (in_req_q.seconds),
    .num_frame_o  (num_frame),
    .time_frame_o (time_frame)
  );

  // request decode and next display state
  always_comb begin
    frame_d     = frame_q;
    colon_d     = colon_q;
    scan_d      = scan_q;
    seg_drive_d = seg_drive_q;
    dig_drive_d = dig_drive_q;
    unique case (in_req_q.opcode)
      OP_TICK: begin
        scan_d      = scan_q + 2'd1;
        seg_drive_d = frame_q[scan_d];
        if (scan_d == COLON_DIGIT && colon_q) begin
          seg_drive_d = seg_drive_d | DP_MASK;
        end
        dig_drive_d = DIGIT_COUNT'(1) << scan_d;
      end
      OP_NUMBER: begin
        frame_d = num_frame;
        colon_d = 1'b0;
      end
      OP_TIME: begin
        frame_d = time_frame;
      end
      OP_COLON: begin
        colon_d = in_req_q.colon_on;
      end
      OP_BLANK: begin
        frame_d = '0;
        colon_d = 1'b0;
      end
      default: ;
    endcase
    out_res_d.segment_lines = seg_drive_d ^ {SEG_W{seg_pol_q}};
    out_res_d.digit_lines   = dig_drive_d ^ {DIGIT_COUNT{dig_pol_q}};
  end

  // display state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      colon_q     <= 1'b0;
      scan_q      <= 2'd0;
      seg_drive_q <= '0;
      dig_drive_q <= '0;
    end else if (advance) begin
      frame_q     <= frame_d;
      colon_q     <= colon_d;
      scan_q      <= scan_d;
      seg_drive_q <= seg_drive_d;
      dig_drive_q <= dig_drive_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= out_res_d;
    end
  end

`ifndef SYNTHESIS
  // at most one digit is ever selected
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(dig_drive_q))
    else $error("more than one digit selected");

  // a tick selects exactly the new scan digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_req_q.opcode == OP_TICK |=> dig_drive_q == (DIGIT_COUNT'(1) << scan_q))
    else $error("digit select does not follow scan digit");

  // a held request stays in the input register unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_req_q))
    else $error("held request lost or changed");
`endif

endmodule

[sv/ssm_frame_gen.sv]
// Builds the frame images for show-number and show-time requests.
// Depends on ssm_pkg for frame_t; purely combinational.
module ssm_frame_gen (
  input  logic [15:0]     num_value_i,
  input  logic [7:0]      minutes_i,
  input  logic [7:0]      seconds_i,
  output ssm_pkg::frame_t num_frame_o,
  output ssm_pkg::frame_t time_frame_o
);
  import ssm_pkg::*;

  // reciprocal multipliers for division of a 16-bit value by powers of ten
  localparam logic [35:0] MUL_10    = 36'd52429;
  localparam logic [35:0] MUL_100   = 36'd167773;
  localparam logic [35:0] MUL_1000  = 36'd67109;
  localparam logic [35:0] MUL_10000 = 36'd107375;
  localparam int unsigned SH_10     = 19;
  localparam int unsigned SH_100    = 24;
  localparam int unsigned SH_1000   = 26;
  localparam int unsigned SH_10000  = 30;
  // tens of a value below 100
  localparam logic [17:0] MUL_TENS  = 18'd205;
  localparam int unsigned SH_TENS   = 11;
  localparam logic [7:0]  MIN_MAX   = 8'd99;
  localparam logic [7:0]  SEC_MAX   = 8'd59;

  // font for decimal digits, bit0 segment a through bit6 segment g
  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // low decimal digit: lo minus ten times hi, where hi = lo / 10
  function automatic logic [3:0] low_digit(input logic [15:0] lo, input logic [15:0] hi);
    logic [15:0] t;
    t = lo - ((hi << 3) + (hi << 1));
    return t[3:0];
  endfunction

  logic [35:0] prod10, prod100, prod1000, prod10000;
  logic [15:0] q1, q2, q3, q4;

  // quotients by 10, 100, 1000, 10000 in parallel
  always_comb begin
    prod10    = {20'd0, num_value_i} * MUL_10;
    prod100   = {20'd0, num_value_i} * MUL_100;
    prod1000  = {20'd0, num_value_i} * MUL_1000;
    prod10000 = {20'd0, num_value_i} * MUL_10000;
    q1 = prod10[SH_10 +: 16];
    q2 = prod100[SH_100 +: 16];
    q3 = prod1000[SH_1000 +: 16];
    q4 = prod10000[SH_10000 +: 6] == 6'd0 ? 16'd0 : {10'd0, prod10000[SH_10000 +: 6]};
  end

  // right-aligned number, leading positions blank
  always_comb begin
    num_frame_o[3] = glyph(low_digit(num_value_i, q1));
    num_frame_o[2] = (q1 != 16'd0) ? glyph(low_digit(q1, q2)) : 8'h00;
    num_frame_o[1] = (q2 != 16'd0) ? glyph(low_digit(q2, q3)) : 8'h00;
    num_frame_o[0] = (q3 != 16'd0) ? glyph(low_digit(q3, q4)) : 8'h00;
  end

  logic [6:0]  min_c, sec_c;
  logic [17:0] min_prod, sec_prod;
  logic [3:0]  min_tens, sec_tens;
  logic [6:0]  min_ones, sec_ones;

  // clamp and split minutes and seconds
  always_comb begin
    min_c    = (minutes_i > MIN_MAX) ? MIN_MAX[6:0] : minutes_i[6:0];
    sec_c    = (seconds_i > SEC_MAX) ? SEC_MAX[6:0] : seconds_i[6:0];
    min_prod = {11'd0, min_c} * MUL_TENS;
    sec_prod = {11'd0, sec_c} * MUL_TENS;
    min_tens = min_prod[SH_TENS +: 4];
    sec_tens = sec_prod[SH_TENS +: 4];
    min_ones = min_c - (({3'd0, min_tens} << 3) + ({3'd0, min_tens} << 1));
    sec_ones = sec_c - (({3'd0, sec_tens} << 3) + ({3'd0, sec_tens} << 1));
    time_frame_o[0] = glyph(min_tens);
    time_frame_o[1] = glyph(min_ones[3:0]);
    time_frame_o[2] = glyph(sec_tens);
    time_frame_o[3] = glyph(sec_ones[3:0]);
  end

endmodule
